@@ rtl/core/gble_pkg.sv @@
// Package for the gap buffer line editor: opcodes, cell control and sizing constants.
`timescale 1ns / 1ps
`default_nettype none
package gble_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned CAPACITY_MAX = 64;
  localparam int unsigned POS_W        = $clog2(CAPACITY_MAX + 1);

  typedef enum logic [2:0] {
    OP_LEFT  = 3'd0,
    OP_RIGHT = 3'd1,
    OP_DEL   = 3'd2,
    OP_INS   = 3'd3,
    OP_SHOW  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_SHR,
    CM_SHL
  } cell_mode_e;

  // SHR: cell lo takes chr, cells above lo take the left neighbour.
  // SHL: cells in [lo, hi) take the right neighbour, cell hi takes wrap.
  typedef struct packed {
    cell_mode_e       mode;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic [7:0]       chr;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/gble_if.sv @@
// Valid/ready channel interfaces for editor commands and show results.
`timescale 1ns / 1ps
`default_nettype none
interface gble_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] char_in;

  modport source (output valid, output opcode, output char_in, input ready);
  modport sink   (input valid, input opcode, input char_in, output ready);
endinterface

interface gble_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_char;
  logic       buffer_empty;
  logic       overflow_seen;

  modport source (output valid, output char_out, output last_char, output buffer_empty,
                  output overflow_seen, input ready);
  modport sink   (input valid, input char_out, input last_char, input buffer_empty,
                  input overflow_seen, output ready);
endinterface
`default_nettype wire

@@ rtl/core/gble_cell.sv @@
// One character cell of the text chain; shifts towards either neighbour on command.
`timescale 1ns / 1ps
`default_nettype none
module gble_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                clk_i,
  input  wire gble_pkg::cell_ctl_t ctl_i,
  input  wire logic [7:0]          left_i,
  input  wire logic [7:0]          right_i,
  input  wire logic [7:0]          wrap_i,
  output logic [7:0]               data_o
);
  import gble_pkg::*;

  localparam logic [POS_W-1:0] MyPos = POS_W'(IDX);

  logic [7:0] data_q;
  logic [7:0] data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctl_i.mode)
      CM_SHR: begin
        if (MyPos == ctl_i.lo) begin
          data_d = ctl_i.chr;
        end else if (MyPos > ctl_i.lo) begin
          data_d = left_i;
        end
      end
      CM_SHL: begin
        if (MyPos == ctl_i.hi) begin
          data_d = wrap_i;
        end else if (MyPos >= ctl_i.lo && MyPos < ctl_i.hi) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

@@ rtl/core/gap_buffer_line_editor.sv @@
// Top level of the gap buffer line editor: command decode, show sequencer and cell chain.
// Edits (left, right, delete, insert): a command is taken every cycle while no show is running.
// Show: the state register enters show, then results are registered one per cycle
// while the sink is ready; the next command is taken once the last result is loaded.
// The text length sets the result count, max(total, 1), as the chain rotates one cell per result.
// Reset clears length counters, overflow flag and handshake state; cell contents are not reset.
`timescale 1ns / 1ps
`default_nettype none
module gap_buffer_line_editor #(
  parameter int unsigned CAPACITY = gble_pkg::CAPACITY_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gble_cmd_if.sink    cmd_i,
  gble_res_if.source  res_o
);
  import gble_pkg::*;

  localparam logic [POS_W-1:0] Cap = POS_W'(CAPACITY);

  typedef enum logic {
    ST_IDLE,
    ST_SHOW
  } state_e;

  state_e           state_q, state_d;
  logic [POS_W-1:0] left_q, left_d;
  logic [POS_W-1:0] total_q, total_d;
  logic [POS_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             res_valid_q, res_valid_d;
  logic [7:0]       res_char_q, res_char_d;
  logic             res_last_q, res_last_d;
  logic             res_empty_q, res_empty_d;
  logic             res_ovf_q, res_ovf_d;

  cell_ctl_t        ctl;
  logic [7:0]       cell_data [CAPACITY];
  logic             accept;
  logic             fire;
  logic             last;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign fire        = !res_valid_q || res_o.ready;
  assign last        = (cnt_q == total_q - POS_W'(1));

  always_comb begin
    state_d     = state_q;
    left_d      = left_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_char_d  = res_char_q;
    res_last_d  = res_last_q;
    res_empty_d = res_empty_q;
    res_ovf_d   = res_ovf_q;
    ctl.mode    = CM_HOLD;
    ctl.lo      = '0;
    ctl.hi      = '0;
    ctl.chr     = cmd_i.char_in;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(cmd_i.opcode))
            OP_LEFT: begin
              if (left_q != '0) begin
                left_d = left_q - POS_W'(1);
              end
            end
            OP_RIGHT: begin
              if (left_q < total_q) begin
                left_d = left_q + POS_W'(1);
              end
            end
            OP_DEL: begin
              if (left_q != '0) begin
                ctl.mode = CM_SHL;
                ctl.lo   = left_q - POS_W'(1);
                ctl.hi   = Cap;
                left_d   = left_q - POS_W'(1);
                total_d  = total_q - POS_W'(1);
              end
            end
            OP_INS: begin
              if (total_q < Cap) begin
                ctl.mode = CM_SHR;
                ctl.lo   = left_q;
                left_d   = left_q + POS_W'(1);
                total_d  = total_q + POS_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_SHOW: begin
              state_d = ST_SHOW;
              cnt_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SHOW: begin
        if (fire) begin
          res_valid_d = 1'b1;
          res_ovf_d   = ovf_q;
          if (total_q == '0) begin
            res_char_d  = '0;
            res_last_d  = 1'b1;
            res_empty_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            // rotate the text one place so the next character reaches cell 0
            res_char_d  = cell_data[0];
            res_last_d  = last;
            res_empty_d = 1'b0;
            ctl.mode    = CM_SHL;
            ctl.lo      = '0;
            ctl.hi      = total_q - POS_W'(1);
            cnt_d       = cnt_q + POS_W'(1);
            if (last) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      left_q      <= '0;
      total_q     <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
      res_char_q  <= '0;
      res_last_q  <= 1'b0;
      res_empty_q <= 1'b0;
      res_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
      res_char_q  <= res_char_d;
      res_last_q  <= res_last_d;
      res_empty_q <= res_empty_d;
      res_ovf_q   <= res_ovf_d;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [7:0] left_nb;
    logic [7:0] right_nb;
    if (g == 0) begin : g_first
      assign left_nb = '0;
    end else begin : g_inner_l
      assign left_nb = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_nb = '0;
    end else begin : g_inner_r
      assign right_nb = cell_data[g+1];
    end
    gble_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .left_i  (left_nb),
      .right_i (right_nb),
      .wrap_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.char_out      = res_char_q;
  assign res_o.last_char     = res_last_q;
  assign res_o.buffer_empty  = res_empty_q;
  assign res_o.overflow_seen = res_ovf_q;

`ifndef SYNTHESIS
  a_cursor_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= total_q) else $error("cursor beyond end of text");

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= Cap) else $error("text length exceeds capacity");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q) else $error("overflow flag cleared");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_empty_q |-> res_last_q) else $error("empty result not marked last");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i.opcode == OP_INS && total_q < Cap |=> total_q == $past(total_q) + POS_W'(1))
    else $error("insert did not grow text");
`endif

endmodule
`default_nettype wire

@@ tb/gap_buffer_line_editor_tb.sv @@
// Self-checking testbench for the gap buffer line editor: directed edits, overflow, random editing.
`timescale 1ns / 1ps
module gap_buffer_line_editor_tb;
  import gble_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
    logic       empty;
    logic       ovf;
  } text_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gble_cmd_if cmd_ch ();
  gble_res_if res_ch ();

  gap_buffer_line_editor #(.CAPACITY(CAP)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_ch),
    .res_o (res_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow gap buffer
  logic [7:0]  gap_text [CAP];
  int unsigned text_left = 0;
  int unsigned text_right = 0;
  logic        overflow_latched = 1'b0;

  text_beat_t  shown_text_q[$];
  int unsigned fail_count = 0;
  int unsigned cmds_taken = 0;
  int unsigned cmd_calm = 0;
  int unsigned res_calm = 0;

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // Mostly short gaps, a few long ones, and occasional stretches with none.
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned roll;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm = $urandom_range(16, 64);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic push_beat(input logic [7:0] chr, input logic last, input logic empty);
    text_beat_t b;
    b.chr   = chr;
    b.last  = last;
    b.empty = empty;
    b.ovf   = overflow_latched;
    shown_text_q = {shown_text_q, b};
  endtask

  task automatic predict_edit(input logic [2:0] op, input logic [7:0] ch);
    int unsigned total;
    int unsigned n;
    total = text_left + text_right;
    n = 0;
    case (op)
      OP_LEFT: begin
        if (text_left != 0) begin
          gap_text[CAP - text_right - 1] = gap_text[text_left - 1];
          text_left--;
          text_right++;
        end
      end
      OP_RIGHT: begin
        if (text_right != 0) begin
          gap_text[text_left] = gap_text[CAP - text_right];
          text_left++;
          text_right--;
        end
      end
      OP_DEL: begin
        if (text_left != 0) text_left--;
      end
      OP_INS: begin
        if (total < CAP) begin
          gap_text[text_left] = ch;
          text_left++;
        end else begin
          overflow_latched = 1'b1;
        end
      end
      OP_SHOW: begin
        if (total == 0) begin
          push_beat(8'h00, 1'b1, 1'b1);
        end else begin
          for (int unsigned i = 0; i < text_left; i++) begin
            n++;
            push_beat(gap_text[i], n == total, 1'b0);
          end
          for (int unsigned i = CAP - text_right; i < CAP; i++) begin
            n++;
            push_beat(gap_text[i], n == total, 1'b0);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_cmd(input logic [2:0] op, input logic [7:0] ch);
    int unsigned gap;
    gap = idle_len(cmd_calm);
    if (gap != 0) begin
      cmd_ch.valid   <= 1'b0;
      cmd_ch.opcode  <= 3'($urandom);
      cmd_ch.char_in <= 8'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.opcode  <= op;
    cmd_ch.char_in <= ch;
    do @(posedge clk_i); while (!cmd_ch.ready);
    predict_edit(op, ch);
    if (op <= OP_SHOW) cmds_taken++;
  endtask

  task automatic insert_char(input logic [7:0] ch);
    send_cmd(OP_INS, ch);
  endtask

  task automatic test_empty_buffer;
    send_cmd(OP_SHOW, 8'($urandom));
    send_cmd(OP_LEFT, 8'($urandom));
    send_cmd(OP_RIGHT, 8'($urandom));
    send_cmd(OP_DEL, 8'($urandom));
    for (int o = int'(OP_SHOW) + 1; o < (1 << $bits(op_e)); o++)
      send_cmd(3'(o), 8'($urandom));
    send_cmd(OP_SHOW, 8'($urandom));
  endtask

  task automatic test_edit_basics;
    insert_char(8'h00);
    insert_char(8'hFF);
    insert_char(8'hA5);
    insert_char(8'h5A);
    send_cmd(OP_SHOW, 8'h00);
    send_cmd(OP_LEFT, 8'h00);
    send_cmd(OP_LEFT, 8'h00);
    insert_char(8'h3C);
    repeat (3) send_cmd(OP_RIGHT, 8'h00);
    send_cmd(OP_DEL, 8'h00);
    repeat (5) send_cmd(OP_LEFT, 8'h00);
    send_cmd(OP_DEL, 8'h00);
    send_cmd(OP_SHOW, 8'h00);
    send_cmd(OP_RIGHT, 8'h00);
    send_cmd(OP_DEL, 8'h00);
    send_cmd(OP_SHOW, 8'h00);
  endtask

  task automatic test_overflow;
    while (text_left + text_right < CAP) begin
      case ($urandom_range(0, 7))
        0: send_cmd(OP_LEFT, 8'h00);
        1: send_cmd(OP_RIGHT, 8'h00);
        default: insert_char(8'($urandom));
      endcase
    end
    send_cmd(OP_SHOW, 8'h00);
    repeat (3) insert_char(8'($urandom));
    send_cmd(OP_SHOW, 8'h00);
    send_cmd(OP_LEFT, 8'h00);
    send_cmd(OP_LEFT, 8'h00);
    send_cmd(OP_RIGHT, 8'h00);
    send_cmd(OP_SHOW, 8'h00);
    repeat (3) send_cmd(OP_DEL, 8'h00);
    insert_char(8'($urandom));
    send_cmd(OP_SHOW, 8'h00);
  endtask

  // Edit sessions: typing bursts, cursor walks, deletes, shows and a little noise.
  task automatic test_random_editing(input int unsigned n_cmds, input bit allow_fill);
    int unsigned stop_at;
    int unsigned len;
    logic [2:0]  op;
    stop_at = cmds_taken + n_cmds;
    while (cmds_taken < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = $urandom_range(1, 8);
          repeat (len) begin
            if (allow_fill || text_left + text_right + 1 < CAP) insert_char(8'($urandom));
          end
        end
        3, 4: begin
          len = $urandom_range(1, 6);
          repeat (len) send_cmd($urandom_range(0, 1) ? OP_LEFT : OP_RIGHT, 8'($urandom));
        end
        5: begin
          len = $urandom_range(1, 5);
          repeat (len) send_cmd(OP_DEL, 8'($urandom));
        end
        6: begin
          if ($urandom_range(0, 3) == 0) begin
            repeat (text_right) send_cmd(OP_RIGHT, 8'($urandom));
            repeat (text_left + 1) send_cmd(OP_DEL, 8'($urandom));
          end else if (allow_fill && $urandom_range(0, 2) == 0) begin
            repeat (CAP - text_left - text_right + $urandom_range(1, 2))
              insert_char(8'($urandom));
          end else begin
            send_cmd(OP_SHOW, 8'($urandom));
          end
        end
        7, 8: send_cmd(OP_SHOW, 8'($urandom));
        default: begin
          if ($urandom_range(0, 2) == 0) begin
            send_cmd(3'($urandom_range(int'(OP_SHOW) + 1, (1 << $bits(op_e)) - 1)),
                     8'($urandom));
          end else begin
            op = 3'($urandom_range(0, int'(OP_SHOW)));
            if (op == OP_INS && !allow_fill && text_left + text_right + 1 >= CAP) op = OP_DEL;
            send_cmd(op, 8'($urandom));
          end
        end
      endcase
    end
  endtask

  // Result sink with random back-pressure
  initial begin
    int unsigned hold;
    hold = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        hold--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        hold = idle_len(res_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    text_beat_t got;
    text_beat_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.chr   = res_ch.char_out;
      got.last  = res_ch.last_char;
      got.empty = res_ch.buffer_empty;
      got.ovf   = res_ch.overflow_seen;
      if (shown_text_q.size() == 0) begin
        log_failure($sformatf("unexpected transaction: char %02h last %0b empty %0b ovf %0b",
                              got.chr, got.last, got.empty, got.ovf));
      end else begin
        want = shown_text_q.pop_front();
        // char_out carries nothing on an empty show
        if (want.empty) got.chr = want.chr;
        if (got !== want)
          log_failure($sformatf({"mismatch: expected char %02h last %0b empty %0b ovf %0b,",
                                 " got char %02h last %0b empty %0b ovf %0b"},
                                want.chr, want.last, want.empty, want.ovf,
                                res_ch.char_out, got.last, got.empty, got.ovf));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("gap_buffer_line_editor verification failed");
    $finish;
  end

  initial begin
    cmd_ch.valid   <= 1'b0;
    cmd_ch.opcode  <= OP_LEFT;
    cmd_ch.char_in <= 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_buffer();
    test_edit_basics();
    test_random_editing(180, 1'b0);
    test_overflow();
    test_random_editing(200, 1'b1);

    cmd_ch.valid <= 1'b0;
    while (shown_text_q.size() != 0) @(posedge clk_i);
    repeat (CAP + 8) @(posedge clk_i);
    if (shown_text_q.size() != 0)
      log_failure($sformatf("%0d results never arrived", shown_text_q.size()));

    if (fail_count == 0) begin
      $display("gap_buffer_line_editor verification clean");
    end else begin
      $display("gap_buffer_line_editor verification failed");
    end
    $finish;
  end

endmodule
